// File: hdl/valve_actuator_mode_control_core_defines.svh
// ----------------------------------------------------------------------------
// Valve actuator mode control: assertion macros
// Shared property macros for the checker, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VALVE_ACTUATOR_MODE_CONTROL_CORE_DEFINES_SVH
`define VALVE_ACTUATOR_MODE_CONTROL_CORE_DEFINES_SVH

// Same-cycle implication.
`define VAMC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VAMC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/vamc_pkg.sv
// ----------------------------------------------------------------------------
// Valve actuator mode control package
// Field widths, mode, position and command codes, and the decode bundle.
// ----------------------------------------------------------------------------
package vamc_pkg;

	// Pin field widths.
	localparam int PROT_W   = 4;
	localparam int SEL_W    = 3;
	localparam int BTN_W    = 2;
	localparam int CMD_W    = 2;
	localparam int LIM_W    = 2;

	// Operating mode codes as reported on the result.
	typedef enum logic [2:0] {
		MODE_REMOTE  = 3'd0,
		MODE_LOCAL   = 3'd1,
		MODE_OFF     = 3'd2,
		MODE_STOP    = 3'd3,
		MODE_HWHEEL  = 3'd4,
		MODE_THERMAL = 3'd5,
		MODE_OTORQUE = 3'd6,
		MODE_CTORQUE = 3'd7
	} mode_t;

	// Valve position codes.
	typedef enum logic [1:0] {
		POS_UNDEF  = 2'd0,
		POS_OPENED = 2'd1,
		POS_CLOSED = 2'd2,
		POS_TRAVEL = 2'd3
	} pos_t;

	// Decoded open/close command.
	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2
	} cmd_t;

	// Everything the flag logic needs from one tick of pins.
	typedef struct packed {
		mode_t mode;
		pos_t  pos;
		cmd_t  cmd;
	} decode_t;

	// Active-low command pair; open wins when both are asserted.
	function automatic cmd_t f_decode_command(input logic [CMD_W-1:0] pins);
		cmd_t c;
		if (!pins[0]) begin
			c = CMD_OPEN;
		end else if (!pins[1]) begin
			c = CMD_CLOSE;
		end else begin
			c = CMD_NONE;
		end
		return c;
	endfunction

endpackage

// File: hdl/valve_actuator_mode_control_core.sv
// ----------------------------------------------------------------------------
// Valve actuator mode control core
// Turns each tick of raw switch levels into motor drives and status feedback.
// ----------------------------------------------------------------------------
// The block takes one tick of pin levels per clock cycle while in_stall is
// low and returns one result per tick, in order. A tick is captured in an
// input register, decoded and combined with the held mode and direction
// flags in one pass of logic, and written to the result register, from which
// the result is offered. A result that waits on a stalled output keeps the
// input register full; the next tick is still taken while the input register
// is empty or moves forward in the same cycle. After reset the held mode is
// remote, both direction flags are clear and no result is valid.
module valve_actuator_mode_control_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [vamc_pkg::PROT_W-1:0] protection_pins,
	input  logic [vamc_pkg::SEL_W-1:0]  selector_pins,
	input  logic [vamc_pkg::BTN_W-1:0]  local_button_pins,
	input  logic [vamc_pkg::CMD_W-1:0]  remote_command_pins,
	input  logic [vamc_pkg::LIM_W-1:0]  limit_pins,
	// Output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        motor_open_drive,
	output logic                        motor_close_drive,
	output logic                        opened_feedback,
	output logic                        closed_feedback,
	output logic                        available_feedback,
	output logic [2:0]                  valve_mode_code,
	output logic [1:0]                  position_code
);

	// Input register
	logic                        valid_s1;
	logic [vamc_pkg::PROT_W-1:0] prot_s1;
	logic [vamc_pkg::SEL_W-1:0]  sel_s1;
	logic [vamc_pkg::BTN_W-1:0]  btn_s1;
	logic [vamc_pkg::CMD_W-1:0]  rcmd_s1;
	logic [vamc_pkg::LIM_W-1:0]  lim_s1;

	// Held state
	vamc_pkg::mode_t prev_mode_q;
	logic            opening_q;
	logic            closing_q;

	// Result register
	logic            out_valid_q;
	logic            open_drive_q;
	logic            close_drive_q;
	logic            opened_fb_q;
	logic            closed_fb_q;
	logic            avail_fb_q;
	vamc_pkg::mode_t mode_q;
	vamc_pkg::pos_t  pos_q;

	vamc_pkg::decode_t dec;
	logic              advance;
	logic              cmd_mode;
	logic              open_set;
	logic              open_next;
	logic              close_set;
	logic              close_next;

	// Flow control: the result register frees up when empty or its transfer completes.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Capture a tick on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			prot_s1 <= protection_pins;
			sel_s1  <= selector_pins;
			btn_s1  <= local_button_pins;
			rcmd_s1 <= remote_command_pins;
			lim_s1  <= limit_pins;
		end
	end

	vamc_decode u_decode (
		.protection_pins     (prot_s1),
		.selector_pins       (sel_s1),
		.local_button_pins   (btn_s1),
		.remote_command_pins (rcmd_s1),
		.limit_pins          (lim_s1),
		.dec                 (dec)
	);

	// Direction flags. Commands count only in a steady remote or local mode;
	// the opening flag is settled first and interlocks the closing flag.
	always_comb begin
		cmd_mode = (dec.mode == prev_mode_q) &&
			((dec.mode == vamc_pkg::MODE_REMOTE) || (dec.mode == vamc_pkg::MODE_LOCAL));
		open_set  = opening_q ||
			((dec.cmd == vamc_pkg::CMD_OPEN) && (dec.pos != vamc_pkg::POS_OPENED) && !closing_q);
		open_next = cmd_mode && open_set &&
			!((dec.pos == vamc_pkg::POS_OPENED) || (dec.cmd == vamc_pkg::CMD_CLOSE));
		close_set = closing_q ||
			((dec.cmd == vamc_pkg::CMD_CLOSE) && (dec.pos != vamc_pkg::POS_CLOSED) && !open_next);
		close_next = cmd_mode && close_set &&
			!((dec.pos == vamc_pkg::POS_CLOSED) || (dec.cmd == vamc_pkg::CMD_OPEN));
	end

	// State moves forward only when a tick enters the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mode_q <= vamc_pkg::MODE_REMOTE;
			opening_q   <= 1'b0;
			closing_q   <= 1'b0;
		end else if (advance && valid_s1) begin
			prev_mode_q <= dec.mode;
			opening_q   <= open_next;
			closing_q   <= close_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			open_drive_q  <= open_next;
			close_drive_q <= close_next;
			opened_fb_q   <= (dec.pos == vamc_pkg::POS_OPENED);
			closed_fb_q   <= (dec.pos == vamc_pkg::POS_CLOSED);
			avail_fb_q    <= (dec.mode == vamc_pkg::MODE_REMOTE);
			mode_q        <= dec.mode;
			pos_q         <= dec.pos;
		end
	end

	assign out_valid          = out_valid_q;
	assign motor_open_drive   = open_drive_q;
	assign motor_close_drive  = close_drive_q;
	assign opened_feedback    = opened_fb_q;
	assign closed_feedback    = closed_fb_q;
	assign available_feedback = avail_fb_q;
	assign valve_mode_code    = mode_q;
	assign position_code      = pos_q;

endmodule

// File: hdl/vamc_decode.sv
// ----------------------------------------------------------------------------
// Valve actuator mode control: pin decoder
// Decodes mode by priority, position from the limits, and the active command.
// ----------------------------------------------------------------------------
module vamc_decode (
	input  logic [vamc_pkg::PROT_W-1:0] protection_pins,
	input  logic [vamc_pkg::SEL_W-1:0]  selector_pins,
	input  logic [vamc_pkg::BTN_W-1:0]  local_button_pins,
	input  logic [vamc_pkg::CMD_W-1:0]  remote_command_pins,
	input  logic [vamc_pkg::LIM_W-1:0]  limit_pins,
	output vamc_pkg::decode_t           dec
);

	vamc_pkg::mode_t mode;
	vamc_pkg::pos_t  pos;

	// Mode: protections first, then the selector contacts (active low).
	always_comb begin
		priority if (!protection_pins[0]) begin
			mode = vamc_pkg::MODE_HWHEEL;
		end else if (protection_pins[1]) begin
			mode = vamc_pkg::MODE_CTORQUE;
		end else if (protection_pins[2]) begin
			mode = vamc_pkg::MODE_OTORQUE;
		end else if (protection_pins[3]) begin
			mode = vamc_pkg::MODE_THERMAL;
		end else if (!selector_pins[0]) begin
			mode = vamc_pkg::MODE_REMOTE;
		end else if (!selector_pins[1]) begin
			mode = vamc_pkg::MODE_LOCAL;
		end else if (!selector_pins[2]) begin
			mode = vamc_pkg::MODE_OFF;
		end else begin
			mode = vamc_pkg::MODE_STOP;
		end
	end

	// Position: both limits at once means the switches disagree.
	always_comb begin
		unique case (limit_pins)
			2'b11:   pos = vamc_pkg::POS_UNDEF;
			2'b01:   pos = vamc_pkg::POS_OPENED;
			2'b10:   pos = vamc_pkg::POS_CLOSED;
			default: pos = vamc_pkg::POS_TRAVEL;
		endcase
	end

	// The command source follows the mode: remote pins in remote, buttons otherwise.
	always_comb begin
		dec.mode = mode;
		dec.pos  = pos;
		if (mode == vamc_pkg::MODE_REMOTE) begin
			dec.cmd = vamc_pkg::f_decode_command(remote_command_pins);
		end else begin
			dec.cmd = vamc_pkg::f_decode_command(local_button_pins);
		end
	end

endmodule

// File: hdl/vamc_checker.sv
// ----------------------------------------------------------------------------
// Valve actuator mode control: port checker
// Watches the top-level ports for drive interlocks and status consistency.
// ----------------------------------------------------------------------------
`include "valve_actuator_mode_control_core_defines.svh"

module vamc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       motor_open_drive,
	input logic       motor_close_drive,
	input logic       opened_feedback,
	input logic       closed_feedback,
	input logic       available_feedback,
	input logic [2:0] valve_mode_code,
	input logic [1:0] position_code
);

	// The relays must never be energized in both directions.
	`VAMC_ASSERT_NOW(a_drive_exclusive, out_valid, !(motor_open_drive && motor_close_drive), "both motor drives active")

	// The motor only runs in remote or local mode.
	`VAMC_ASSERT_NOW(a_drive_mode, out_valid && (motor_open_drive || motor_close_drive), (valve_mode_code == vamc_pkg::MODE_REMOTE) || (valve_mode_code == vamc_pkg::MODE_LOCAL), "motor driven outside a command mode")

	// Availability tracks the remote mode exactly.
	`VAMC_ASSERT_NOW(a_available, out_valid, available_feedback == (valve_mode_code == vamc_pkg::MODE_REMOTE), "available feedback disagrees with mode")

	// Position feedback matches the position code.
	`VAMC_ASSERT_NOW(a_pos_feedback, out_valid, (opened_feedback == (position_code == vamc_pkg::POS_OPENED)) && (closed_feedback == (position_code == vamc_pkg::POS_CLOSED)), "position feedback disagrees with code")

	// A stalled result holds.
	`VAMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(valve_mode_code) && $stable(motor_open_drive) && $stable(motor_close_drive), "stalled result changed")

endmodule

bind valve_actuator_mode_control_core vamc_checker u_vamc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.motor_open_drive   (motor_open_drive),
	.motor_close_drive  (motor_close_drive),
	.opened_feedback    (opened_feedback),
	.closed_feedback    (closed_feedback),
	.available_feedback (available_feedback),
	.valve_mode_code    (valve_mode_code),
	.position_code      (position_code)
);

// File: dv/valve_actuator_mode_control_core_tb.sv
// ----------------------------------------------------------------------------
// Valve actuator mode control core testbench
// Offers ticks of switch levels through a directed table and then random
// well-formed remote and local runs with noise between them. Each result is checked
// against its typed row or a local predictor of mode, position and drive flags.
// ----------------------------------------------------------------------------
module valve_actuator_mode_control_core_tb;
	import vamc_pkg::*;

	localparam int RAND_TICKS   = 1600;
	localparam int HOLD_CYCLES  = 80;
	localparam int REPORT_LIMIT = 10;
	localparam int DIR_ROWS     = 24;

	// One result as it leaves the block.
	typedef struct packed {
		logic  open_drv;
		logic  close_drv;
		logic  opened_fb;
		logic  closed_fb;
		logic  avail_fb;
		mode_t mode;
		pos_t  pos;
	} drive_status_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		logic [PROT_W-1:0] prot;
		logic [SEL_W-1:0]  sel;
		logic [BTN_W-1:0]  btn;
		logic [CMD_W-1:0]  rcmd;
		logic [LIM_W-1:0]  lim;
		logic              typed;
		logic              want_open;
		logic              want_close;
		mode_t             want_mode;
		pos_t              want_pos;
	} tick_row_t;

	localparam tick_row_t TICK_TABLE [0:DIR_ROWS-1] = '{
		// Idle tick right after reset: remote, travelling, motor off.
		'{4'b0001, 3'b110, 2'b11, 2'b11, 2'b00, 1'b1, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		// All pins but the limits low: handwheel engaged, both limits give undefined.
		'{4'b0000, 3'b000, 2'b00, 2'b00, 2'b11, 1'b1, 1'b0, 1'b0, MODE_HWHEEL, POS_UNDEF},
		// All pins high: close torque beats the other trips.
		'{4'b1111, 3'b111, 2'b11, 2'b11, 2'b11, 1'b1, 1'b0, 1'b0, MODE_CTORQUE, POS_UNDEF},
		'{4'b0101, 3'b000, 2'b00, 2'b00, 2'b01, 1'b1, 1'b0, 1'b0, MODE_OTORQUE, POS_OPENED},
		'{4'b1001, 3'b000, 2'b00, 2'b00, 2'b10, 1'b1, 1'b0, 1'b0, MODE_THERMAL, POS_CLOSED},
		'{4'b0001, 3'b111, 2'b00, 2'b00, 2'b00, 1'b1, 1'b0, 1'b0, MODE_STOP, POS_TRAVEL},
		'{4'b0001, 3'b011, 2'b00, 2'b00, 2'b00, 1'b1, 1'b0, 1'b0, MODE_OFF, POS_TRAVEL},
		// Entering local is a mode change, so nothing latches yet.
		'{4'b0001, 3'b101, 2'b11, 2'b00, 2'b00, 1'b1, 1'b0, 1'b0, MODE_LOCAL, POS_TRAVEL},
		// Local open, hold, reach the opened limit.
		'{4'b0001, 3'b101, 2'b10, 2'b11, 2'b00, 1'b0, 1'b0, 1'b0, MODE_LOCAL, POS_TRAVEL},
		'{4'b0001, 3'b101, 2'b11, 2'b11, 2'b00, 1'b0, 1'b0, 1'b0, MODE_LOCAL, POS_TRAVEL},
		'{4'b0001, 3'b101, 2'b11, 2'b11, 2'b01, 1'b0, 1'b0, 1'b0, MODE_LOCAL, POS_TRAVEL},
		// Local close, then the opposite button drops it, then both buttons.
		'{4'b0001, 3'b101, 2'b01, 2'b11, 2'b01, 1'b0, 1'b0, 1'b0, MODE_LOCAL, POS_TRAVEL},
		'{4'b0001, 3'b101, 2'b10, 2'b11, 2'b00, 1'b0, 1'b0, 1'b0, MODE_LOCAL, POS_TRAVEL},
		'{4'b0001, 3'b101, 2'b00, 2'b11, 2'b00, 1'b0, 1'b0, 1'b0, MODE_LOCAL, POS_TRAVEL},
		// Back to remote: the change clears the running flag.
		'{4'b0001, 3'b010, 2'b11, 2'b10, 2'b00, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		'{4'b0001, 3'b010, 2'b11, 2'b10, 2'b00, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		// Close while opening drops the opening flag and latches closing in the same tick.
		'{4'b0001, 3'b010, 2'b11, 2'b01, 2'b00, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		'{4'b0001, 3'b010, 2'b11, 2'b01, 2'b00, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		// Closed limit reached, then commands at the target limit do nothing.
		'{4'b0001, 3'b010, 2'b11, 2'b01, 2'b10, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		'{4'b0001, 3'b010, 2'b11, 2'b01, 2'b10, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		'{4'b0001, 3'b010, 2'b11, 2'b10, 2'b01, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		// Both commands with both limits: open wins and the position is undefined.
		'{4'b0001, 3'b010, 2'b11, 2'b00, 2'b11, 1'b0, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL},
		// A thermal trip drops the drive at once.
		'{4'b1001, 3'b010, 2'b11, 2'b00, 2'b11, 1'b1, 1'b0, 1'b0, MODE_THERMAL, POS_UNDEF},
		'{4'b0001, 3'b110, 2'b11, 2'b11, 2'b00, 1'b1, 1'b0, 1'b0, MODE_REMOTE, POS_TRAVEL}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [PROT_W-1:0] protection_pins;
	logic [SEL_W-1:0]  selector_pins;
	logic [BTN_W-1:0]  local_button_pins;
	logic [CMD_W-1:0]  remote_command_pins;
	logic [LIM_W-1:0]  limit_pins;
	logic              out_valid;
	logic              out_stall;
	logic              motor_open_drive;
	logic              motor_close_drive;
	logic              opened_feedback;
	logic              closed_feedback;
	logic              available_feedback;
	logic [2:0]        valve_mode_code;
	logic [1:0]        position_code;

	// Predictor state: held mode and the two direction flags.
	mode_t held_mode     = MODE_REMOTE;
	logic  open_latched  = 1'b0;
	logic  close_latched = 1'b0;

	drive_status_t drive_status_q [$];
	int            mismatch_count = 0;
	int            ticks_sent     = 0;
	int            ticks_checked  = 0;
	int            drive_on_count = 0;
	logic [7:0]    modes_seen     = '0;
	bit            calm           = 1'b0;
	bit            hold_req       = 1'b0;

	valve_actuator_mode_control_core u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.protection_pins     (protection_pins),
		.selector_pins       (selector_pins),
		.local_button_pins   (local_button_pins),
		.remote_command_pins (remote_command_pins),
		.limit_pins          (limit_pins),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.motor_open_drive    (motor_open_drive),
		.motor_close_drive   (motor_close_drive),
		.opened_feedback     (opened_feedback),
		.closed_feedback     (closed_feedback),
		.available_feedback  (available_feedback),
		.valve_mode_code     (valve_mode_code),
		.position_code       (position_code)
	);

	// Clock with a period of 20.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Works out the result of one tick and advances the held mode and flags.
	function automatic drive_status_t predict_actuator_tick(
		input logic [PROT_W-1:0] p,
		input logic [SEL_W-1:0]  s,
		input logic [BTN_W-1:0]  b,
		input logic [CMD_W-1:0]  r,
		input logic [LIM_W-1:0]  l
	);
		mode_t            m;
		pos_t             ps;
		cmd_t             c;
		logic [CMD_W-1:0] pins;
		drive_status_t    res;

		// Mode by strict priority: protections first, then the selector.
		if (!p[0]) begin
			m = MODE_HWHEEL;
		end else if (p[1]) begin
			m = MODE_CTORQUE;
		end else if (p[2]) begin
			m = MODE_OTORQUE;
		end else if (p[3]) begin
			m = MODE_THERMAL;
		end else if (!s[0]) begin
			m = MODE_REMOTE;
		end else if (!s[1]) begin
			m = MODE_LOCAL;
		end else if (!s[2]) begin
			m = MODE_OFF;
		end else begin
			m = MODE_STOP;
		end

		case (l)
			2'b11: ps = POS_UNDEF;
			2'b01: ps = POS_OPENED;
			2'b10: ps = POS_CLOSED;
			default: ps = POS_TRAVEL;
		endcase

		// Flags only move in a steady remote or local mode.
		if (m == held_mode && (m == MODE_REMOTE || m == MODE_LOCAL)) begin
			pins = (m == MODE_REMOTE) ? r : b;
			if (!pins[0]) begin
				c = CMD_OPEN;
			end else if (!pins[1]) begin
				c = CMD_CLOSE;
			end else begin
				c = CMD_NONE;
			end
			if (c == CMD_OPEN && ps != POS_OPENED && !close_latched) begin
				open_latched = 1'b1;
			end
			if (open_latched && (ps == POS_OPENED || c == CMD_CLOSE)) begin
				open_latched = 1'b0;
			end
			if (c == CMD_CLOSE && ps != POS_CLOSED && !open_latched) begin
				close_latched = 1'b1;
			end
			if (close_latched && (ps == POS_CLOSED || c == CMD_OPEN)) begin
				close_latched = 1'b0;
			end
		end else begin
			open_latched  = 1'b0;
			close_latched = 1'b0;
		end
		held_mode = m;

		res.open_drv  = open_latched;
		res.close_drv = close_latched;
		res.opened_fb = (ps == POS_OPENED);
		res.closed_fb = (ps == POS_CLOSED);
		res.avail_fb  = (m == MODE_REMOTE);
		res.mode      = m;
		res.pos       = ps;
		return res;
	endfunction

	// Offers one tick, waits for its transfer and queues its expected result.
	task automatic offer_tick(
		input logic [PROT_W-1:0] p,
		input logic [SEL_W-1:0]  s,
		input logic [BTN_W-1:0]  b,
		input logic [CMD_W-1:0]  r,
		input logic [LIM_W-1:0]  l,
		input logic              typed,
		input drive_status_t     typed_res
	);
		drive_status_t res;

		while (!calm && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid            <= 1'b1;
		protection_pins     <= p;
		selector_pins       <= s;
		local_button_pins   <= b;
		remote_command_pins <= r;
		limit_pins          <= l;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		res = predict_actuator_tick(p, s, b, r, l);
		if (typed) begin
			res = typed_res;
		end
		drive_status_q.push_back(res);
		ticks_sent++;
	endtask

	// Receiver: random stalls, a calm window, and one long hold-off on request.
	initial begin
		int rx_cycle;
		int hold_left;

		rx_cycle  = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (rx_cycle >= 600 && rx_cycle < 1200) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 16);
			end
		end
	end

	// Result checker: every output transfer is matched against the oldest expectation.
	always @(posedge clk) begin
		drive_status_t got;
		drive_status_t want;

		if (arst_n && out_valid && !out_stall) begin
			got.open_drv  = motor_open_drive;
			got.close_drv = motor_close_drive;
			got.opened_fb = opened_feedback;
			got.closed_fb = closed_feedback;
			got.avail_fb  = available_feedback;
			got.mode      = mode_t'(valve_mode_code);
			got.pos       = pos_t'(position_code);
			if (drive_status_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%0t: result with no expectation waiting: %p", $realtime, got);
				end
			end else begin
				want = drive_status_q.pop_front();
				ticks_checked++;
				if (got.mode !== want.mode || got.pos !== want.pos
						|| got.open_drv !== want.open_drv || got.close_drv !== want.close_drv
						|| got.opened_fb !== want.opened_fb
						|| got.closed_fb !== want.closed_fb
						|| got.avail_fb !== want.avail_fb) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: result %0d mismatch", $realtime, ticks_checked);
						$display("  expected open=%b close=%b opened=%b closed=%b avail=%b mode=%0d pos=%0d",
							want.open_drv, want.close_drv, want.opened_fb, want.closed_fb,
							want.avail_fb, want.mode, want.pos);
						$display("  actual   open=%b close=%b opened=%b closed=%b avail=%b mode=%0d pos=%0d",
							got.open_drv, got.close_drv, got.opened_fb, got.closed_fb,
							got.avail_fb, valve_mode_code, position_code);
					end
				end
				if (got.mode === want.mode) begin
					modes_seen[want.mode] = 1'b1;
				end
				if (want.open_drv || want.close_drv) begin
					drive_on_count++;
				end
			end
		end
	end

	// Stimulus: reset, the directed table, then random runs.
	initial begin
		int               i;
		int               k;
		int               seq_len;
		int               rand_sent;
		int               pick;
		bit               noise;
		bit               use_remote;
		logic [PROT_W-1:0] p;
		logic [SEL_W-1:0]  s;
		logic [BTN_W-1:0]  b;
		logic [CMD_W-1:0]  r;
		logic [LIM_W-1:0]  l;
		logic [CMD_W-1:0]  active;
		tick_row_t         row;
		drive_status_t     typed_res;

		arst_n              = 1'b0;
		in_valid            = 1'b0;
		protection_pins     = '0;
		selector_pins       = '0;
		local_button_pins   = '0;
		remote_command_pins = '0;
		limit_pins          = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (i = 0; i < DIR_ROWS; i++) begin
			row = TICK_TABLE[i];
			typed_res.open_drv  = row.want_open;
			typed_res.close_drv = row.want_close;
			typed_res.opened_fb = (row.want_pos == POS_OPENED);
			typed_res.closed_fb = (row.want_pos == POS_CLOSED);
			typed_res.avail_fb  = (row.want_mode == MODE_REMOTE);
			typed_res.mode      = row.want_mode;
			typed_res.pos       = row.want_pos;
			offer_tick(row.prot, row.sel, row.btn, row.rcmd, row.lim, row.typed, typed_res);
		end

		// Random part: mostly steady remote or local runs, some noise between them.
		rand_sent  = 0;
		use_remote = 1'b1;
		while (rand_sent < RAND_TICKS) begin
			noise = ($urandom_range(0, 99) < 15);
			if (noise) begin
				seq_len = $urandom_range(1, 3);
			end else begin
				seq_len    = $urandom_range(3, 24);
				use_remote = 1'($urandom_range(0, 1));
			end
			for (k = 0; k < seq_len && rand_sent < RAND_TICKS; k++) begin
				if (noise) begin
					p = 4'($urandom_range(0, 15));
					s = 3'($urandom_range(0, 7));
					b = 2'($urandom_range(0, 3));
					r = 2'($urandom_range(0, 3));
					l = 2'($urandom_range(0, 3));
				end else begin
					// An occasional protection trip breaks the run.
					p = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : 4'b0001;
					if (use_remote) begin
						s = {2'($urandom_range(0, 3)), 1'b0};
					end else begin
						s = {1'($urandom_range(0, 1)), 2'b01};
					end
					pick = $urandom_range(0, 9);
					if (pick < 4) begin
						active = 2'b11;
					end else if (pick < 6) begin
						active = 2'b10;
					end else if (pick < 8) begin
						active = 2'b01;
					end else if (pick == 8) begin
						active = 2'b00;
					end else begin
						active = 2'($urandom_range(0, 3));
					end
					if (use_remote) begin
						r = active;
						b = 2'($urandom_range(0, 3));
					end else begin
						b = active;
						r = 2'($urandom_range(0, 3));
					end
					pick = $urandom_range(0, 9);
					if (pick < 5) begin
						l = 2'b00;
					end else if (pick < 7) begin
						l = 2'b01;
					end else if (pick < 9) begin
						l = 2'b10;
					end else begin
						l = 2'b11;
					end
				end

				calm = (rand_sent >= 250 && rand_sent < 650);
				if (rand_sent == 800) begin
					hold_req = 1'b1;
				end
				// Let the pipeline drain completely before going on.
				if (rand_sent == 1200) begin
					in_valid <= 1'b0;
					do begin
						@(posedge clk);
					end while (drive_status_q.size() != 0);
				end
				offer_tick(p, s, b, r, l, 1'b0, typed_res);
				rand_sent++;
			end
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// Wait for the last results, then a few more cycles for strays.
		do begin
			@(posedge clk);
		end while (drive_status_q.size() != 0);
		repeat (8) @(posedge clk);

		$display("Checked %0d of %0d ticks (%0d from the table), modes seen %b, drive on in %0d.",
			ticks_checked, ticks_sent, DIR_ROWS, modes_seen, drive_on_count);
		$display("Output held off for %0d cycles once; input drained once mid-run.",
			HOLD_CYCLES);
		if (mismatch_count == 0 && drive_status_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/vamc_pkg.sv
hdl/vamc_decode.sv
hdl/valve_actuator_mode_control_core.sv
hdl/vamc_checker.sv
dv/valve_actuator_mode_control_core_tb.sv
